>>> rtl/assert_macros.svh
// assertion macros for the rtl files, included by ordered_list_engine.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/ole_pkg.sv
// package for the ordered list engine: sizes, opcodes, status codes, cell control
`default_nettype none
package ole_pkg;
    localparam int CAPACITY = 16;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int POS_W = 5;

    typedef enum logic [3:0] {
        OP_INS_FIRST = 4'd0,
        OP_INS_LAST  = 4'd1,
        OP_INS_AT    = 4'd2,
        OP_DEL_FIRST = 4'd3,
        OP_DEL_LAST  = 4'd4,
        OP_DEL_AT    = 4'd5,
        OP_SEARCH    = 4'd6,
        OP_REVERSE   = 4'd7,
        OP_SORT      = 4'd8,
        OP_CLEAR     = 4'd9,
        OP_READOUT   = 4'd10
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_RANGE    = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // operation that every cell performs in a cycle
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_INSERT = 3'd1,
        CELL_DELETE = 3'd2,
        CELL_ROTATE = 3'd3,
        CELL_SORT   = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [IDX_W-1:0]  pos;
        logic [CNT_W-1:0]  count;
        logic [31:0]       value;
        logic [IDX_W-1:0]  limit;
    } cell_ctrl_t;
endpackage
`default_nettype wire

>>> rtl/ole_cell.sv
// one list cell: holds an entry and trades with its neighbors
`default_nettype none
module ole_cell
    import ole_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [IDX_W-1:0]  index,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [31:0]       left_data,
    input  wire logic [31:0]       right_data,
    input  wire logic              lt_right,
    input  wire logic              lt_left,
    output logic [31:0]            data
);
    logic [31:0] data_reg;
    logic [31:0] data_next;
    logic        odd;

    assign data = data_reg;
    assign odd = index[0];

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            CELL_INSERT:
            begin
                if (index == ctrl.pos)
                    data_next = ctrl.value;
                else if (index > ctrl.pos)
                    data_next = left_data;
            end
            CELL_DELETE:
            begin
                if (index >= ctrl.pos)
                    data_next = right_data;
            end
            // rotate the first limit+1 cells one step toward the front end
            CELL_ROTATE:
            begin
                if (index < ctrl.limit)
                    data_next = (index >= ctrl.pos) ? right_data : data_reg;
                else if (index == ctrl.limit)
                    data_next = ctrl.value;
            end
            // odd-even transposition step; pos[0] is the phase
            CELL_SORT:
            begin
                if ((odd == ctrl.pos[0]) && ({1'b0, index} + 1'b1 < ctrl.count))
                begin
                    if (lt_right)
                        data_next = right_data;
                end
                else if ((odd != ctrl.pos[0]) && (index != '0) &&
                         ({1'b0, index} < ctrl.count))
                begin
                    if (lt_left)
                        data_next = left_data;
                end
            end
            default:
                data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end
endmodule
`default_nettype wire

>>> rtl/ordered_list_engine.sv
// top level of the ordered list engine: sequencer and row of cells
//
//  channel  direction  handshake          fields
//  command  in         start & !busy      opcode value_in position_in
//  result   out        strobe (no stall)  status value_out position_out length last
//
// edits, clear and unused opcodes: S_IDLE accepts start, S_DONE registers the result
// search and readout walk the row, one cell per cycle
// reverse: CAPACITY-1 rotate passes at most; sort: CAPACITY odd-even steps
// reset clears only the count, the sequencer state and the result strobe; entry storage is not reset
// busy is high from the accepting edge until the last result has been shown
`default_nettype none
module ordered_list_engine
    import ole_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [3:0]          opcode,
    input  wire logic signed [31:0]  value_in,
    input  wire logic [POS_W-1:0]    position_in,
    output logic                     strobe,
    output logic [2:0]               status,
    output logic signed [31:0]       value_out,
    output logic [POS_W-1:0]         position_out,
    output logic [POS_W-1:0]         length,
    output logic                     last
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_WALK  = 5'b00010,
        S_REV   = 5'b00100,
        S_SORT  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [3:0]        op_reg, op_next;
    logic [31:0]       key_reg, key_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic [IDX_W-1:0]  lim_reg, lim_next;
    logic [2:0]        st_reg, st_next;
    logic              strobe_reg, strobe_next;
    logic [2:0]        ost_reg, ost_next;
    logic [31:0]       oval_reg, oval_next;
    logic [POS_W-1:0]  opos_reg, opos_next;
    logic              olast_reg, olast_next;
    logic [CNT_W-1:0]  olen_reg, olen_next;

    cell_ctrl_t        ctrl;
    logic [31:0]       cell_data [CAPACITY];
    logic [31:0]       head;
    logic [CNT_W-1:0]  pos_ext;

    assign head = cell_data[step_reg];
    assign pos_ext = CNT_W'(position_in);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [31:0] l_d, r_d;
            logic        lt_r, lt_l;
            assign l_d = (g == 0) ? cell_data[0] : cell_data[(g == 0) ? 0 : g-1];
            assign r_d = (g == CAPACITY-1) ? cell_data[g]
                       : cell_data[(g == CAPACITY-1) ? g : g+1];
            assign lt_r = $signed(r_d) < $signed(cell_data[g]);
            assign lt_l = $signed(cell_data[g]) < $signed(l_d);
            ole_cell u_cell (
                .clk        (clk),
                .index      (IDX_W'(g)),
                .ctrl       (ctrl),
                .left_data  (l_d),
                .right_data (r_d),
                .lt_right   (lt_r),
                .lt_left    (lt_l),
                .data       (cell_data[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        step_next   = step_reg;
        lim_next    = lim_reg;
        st_next     = st_reg;
        strobe_next = 1'b0;
        ost_next    = ost_reg;
        oval_next   = oval_reg;
        opos_next   = opos_reg;
        olast_next  = olast_reg;
        olen_next   = olen_reg;
        ctrl        = '{op: CELL_HOLD, pos: '0, count: count_reg, value: '0, limit: '0};
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && !strobe_reg)
                begin
                    op_next   = opcode;
                    key_next  = value_in;
                    step_next = '0;
                    st_next   = ST_OK;
                    state_next = S_DONE;
                    unique case (opcode)
                        OP_INS_FIRST, OP_INS_LAST, OP_INS_AT:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                                st_next = ST_FULL;
                            else if (opcode == OP_INS_AT && pos_ext > count_reg)
                                st_next = ST_RANGE;
                            else
                            begin
                                ctrl.op = CELL_INSERT;
                                ctrl.value = value_in;
                                ctrl.pos = (opcode == OP_INS_FIRST) ? '0
                                         : (opcode == OP_INS_LAST) ? IDX_W'(count_reg)
                                         : IDX_W'(position_in);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT:
                        begin
                            if (count_reg == '0)
                                st_next = ST_EMPTY;
                            else if (opcode == OP_DEL_AT && pos_ext >= count_reg)
                                st_next = ST_RANGE;
                            else
                            begin
                                ctrl.op = CELL_DELETE;
                                ctrl.pos = (opcode == OP_DEL_FIRST) ? '0
                                         : (opcode == OP_DEL_LAST)
                                           ? IDX_W'(count_reg - 1'b1)
                                           : IDX_W'(position_in);
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_SEARCH, OP_READOUT:
                        begin
                            if (count_reg == '0)
                                st_next = ST_EMPTY;
                            else
                                state_next = S_WALK;
                        end
                        OP_REVERSE:
                        begin
                            if (count_reg == '0)
                                st_next = ST_EMPTY;
                            else if (count_reg > 1)
                            begin
                                lim_next = IDX_W'(count_reg - 1'b1);
                                state_next = S_REV;
                            end
                        end
                        OP_SORT:
                        begin
                            if (count_reg == '0)
                                st_next = ST_EMPTY;
                            else
                                state_next = S_SORT;
                        end
                        OP_CLEAR:
                            count_next = '0;
                        default:
                            st_next = ST_OK;
                    endcase
                end
            end
            S_WALK:
            begin
                if (op_reg == OP_READOUT)
                begin
                    strobe_next = 1'b1;
                    ost_next  = ST_OK;
                    oval_next = head;
                    opos_next = POS_W'(step_reg);
                    olen_next = count_reg;
                    olast_next = ({1'b0, step_reg} + 1'b1 == count_reg);
                    step_next = step_reg + 1'b1;
                    if (olast_next)
                        state_next = S_IDLE;
                end
                else if (head == key_reg)
                begin
                    st_next = ST_OK;
                    state_next = S_DONE;
                end
                else if ({1'b0, step_reg} + 1'b1 == count_reg)
                begin
                    st_next = ST_NOTFOUND;
                    step_next = '0;
                    state_next = S_DONE;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            // pass k: rotate cells 0..lim-k one place, moving cell 0 to the end
            S_REV:
            begin
                ctrl.op    = CELL_ROTATE;
                ctrl.pos   = '0;
                ctrl.limit = lim_reg - step_reg;
                ctrl.value = cell_data[0];
                step_next  = step_reg + 1'b1;
                if (step_next == lim_reg)
                begin
                    step_next  = '0;
                    state_next = S_DONE;
                end
            end
            S_SORT:
            begin
                ctrl.op  = CELL_SORT;
                ctrl.pos = step_reg;
                step_next = step_reg + 1'b1;
                if (step_reg == IDX_W'(CAPACITY - 1))
                begin
                    step_next  = '0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                strobe_next = 1'b1;
                ost_next  = st_reg;
                oval_next = '0;
                opos_next = (op_reg == OP_SEARCH && st_reg == ST_OK)
                          ? POS_W'(step_reg) : '0;
                olen_next = count_reg;
                olast_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        step_reg  <= step_next;
        lim_reg   <= lim_next;
        st_reg    <= st_next;
        ost_reg   <= ost_next;
        oval_reg  <= oval_next;
        opos_reg  <= opos_next;
        olast_reg <= olast_next;
        olen_reg  <= olen_next;
    end

    assign busy         = (state_reg != S_IDLE) || strobe_reg;
    assign strobe       = strobe_reg;
    assign status       = ost_reg;
    assign value_out    = oval_reg;
    assign position_out = opos_reg;
    assign length       = POS_W'(olen_reg);
    assign last         = olast_reg;

`include "assert_macros.svh"
    `ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `ASSERT_IMPL(a_strobe_busy, strobe_reg, busy)
    `ASSERT_NEXT(a_done_strobe, state_reg == S_DONE, strobe_reg && olast_reg)
    `ASSERT_IMPL(a_len_out, strobe_reg, olen_reg == count_reg)
endmodule
`default_nettype wire
